### rtl/pvd_pkg.sv
// ----------------------------------------------------------------------------
// pvd_pkg
// Shared types and constants for the prefix varint stream decoder.
// ----------------------------------------------------------------------------
package pvd_pkg;

    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 32;
    localparam int VALUE_W = 64;
    localparam int LEFT_W  = 3;

    // Trailing byte counts for each prefix form
    localparam logic [LEFT_W-1:0] LEFT_NONE = 3'd0;
    localparam logic [LEFT_W-1:0] LEFT_TWO  = 3'd1;
    localparam logic [LEFT_W-1:0] LEFT_FOUR = 3'd3;
    localparam logic [LEFT_W-1:0] LEFT_FULL = 3'd4;

    // Payload masks of the first byte
    localparam logic [BYTE_W-1:0] LOW6_MASK = 8'h3F;
    localparam logic [BYTE_W-1:0] LOW5_MASK = 8'h1F;

    // Completed 32-bit word handed from the decoder to the pairing stage
    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] data;
    } t_word;

endpackage

### rtl/pvd_decode.sv
// ----------------------------------------------------------------------------
// pvd_decode
// Input byte register and prefix-length word assembly.
// ----------------------------------------------------------------------------
module pvd_decode (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [pvd_pkg::BYTE_W-1:0] i_byte,
    input  logic                  i_dn_ready,   // pairing stage can take a word
    output pvd_pkg::t_word        o_word
);
    import pvd_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic [LEFT_W-1:0] r_left;
    logic [WORD_W-1:0] r_acc;

    logic              w_adv;
    logic [LEFT_W-1:0] n_left;
    logic [WORD_W-1:0] n_acc;
    logic [WORD_W-1:0] w_shift;
    logic [LEFT_W-1:0] w_left_dec;

    // Held byte moves on whenever the pairing stage has room
    assign w_adv   = r_in_valid && i_dn_ready;
    assign o_ready = !r_in_valid || i_dn_ready;

    // Input request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_in_byte <= i_byte;
        end
    end

    assign w_shift    = {r_acc[WORD_W-BYTE_W-1:0], r_in_byte};
    assign w_left_dec = r_left - LEFT_W'(1);

    // Word assembly
    always_comb begin
        n_left       = r_left;
        n_acc        = r_acc;
        o_word.valid = 1'b0;
        o_word.data  = w_shift;
        if (w_adv) begin
            if (r_left != LEFT_NONE) begin
                n_left = w_left_dec;
                if (w_left_dec == LEFT_NONE) begin
                    o_word.valid = 1'b1;
                    n_acc        = '0;
                end else begin
                    n_acc = w_shift;
                end
            end else if (!r_in_byte[7]) begin
                // single-byte form
                o_word.valid = 1'b1;
                o_word.data  = {{(WORD_W-BYTE_W){1'b0}}, r_in_byte};
                n_acc        = '0;
            end else if (!r_in_byte[6]) begin
                n_acc  = {{(WORD_W-BYTE_W){1'b0}}, r_in_byte & LOW6_MASK};
                n_left = LEFT_TWO;
            end else if (!r_in_byte[5]) begin
                n_acc  = {{(WORD_W-BYTE_W){1'b0}}, r_in_byte & LOW5_MASK};
                n_left = LEFT_FOUR;
            end else begin
                // full 32-bit form, first byte payload dropped
                n_acc  = '0;
                n_left = LEFT_FULL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= LEFT_NONE;
            r_acc  <= '0;
        end else begin
            r_left <= n_left;
            r_acc  <= n_acc;
        end
    end

endmodule

### rtl/pvd_pair.sv
// ----------------------------------------------------------------------------
// pvd_pair
// Quad-mode word pairing and the result register.
// ----------------------------------------------------------------------------
module pvd_pair (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic                        i_cfg_wr_data,
    input  pvd_pkg::t_word              i_word,
    output logic                        o_ready,
    output logic                        o_valid,
    input  logic                        i_out_ready,
    output logic [pvd_pkg::VALUE_W-1:0] o_value
);
    import pvd_pkg::*;

    logic               r_quad;
    logic               r_second;
    logic [WORD_W-1:0]  r_low;
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_value;

    logic               w_emit;
    logic               w_hold_low;

    // Result register has room when empty or draining this cycle
    assign o_ready    = !r_out_valid || i_out_ready;
    assign w_emit     = i_word.valid && (!r_quad || r_second);
    assign w_hold_low = i_word.valid && r_quad && !r_second;

    // Mode and pairing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quad   <= 1'b0;
            r_second <= 1'b0;
            r_low    <= '0;
        end else if (i_cfg_wr_en) begin
            r_quad   <= i_cfg_wr_data;
            r_second <= 1'b0;
        end else if (w_hold_low) begin
            r_low    <= i_word.data;
            r_second <= 1'b1;
        end else if (w_emit) begin
            r_second <= 1'b0;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_emit) begin
            r_out_value <= r_quad ? {i_word.data, r_low}
                                  : {{(VALUE_W-WORD_W){1'b0}}, i_word.data};
        end
    end

    assign o_valid = r_out_valid;
    assign o_value = r_out_value;

endmodule

### rtl/prefix_varint_stream_decoder.sv
// A byte that completes a value reaches the master side after its request is
// taken (input register, decode, then result register).
// Throughput: one byte per cycle unless the master side stalls; set by the
// single-pass decode between the input register and the result register.
// Reset (synchronous, active low): normal mode, no partial word, no result.
// ----------------------------------------------------------------------------
// prefix_varint_stream_decoder
// Decodes prefix-length variable integers from a byte stream, optionally
// pairing two 32-bit words into one 64-bit value (quad mode).
// ----------------------------------------------------------------------------
module prefix_varint_stream_decoder (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic                        i_cfg_wr_data,   // quad_mode
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [pvd_pkg::BYTE_W-1:0]  s_axis_tdata,    // [7:0] data_byte
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [pvd_pkg::VALUE_W-1:0] m_axis_tdata     // [63:0] value
);
    import pvd_pkg::*;

    t_word w_word;
    logic  w_dn_ready;

    pvd_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_byte     (s_axis_tdata),
        .i_dn_ready (w_dn_ready),
        .o_word     (w_word)
    );

    pvd_pair u_pair (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_word        (w_word),
        .o_ready       (w_dn_ready),
        .o_valid       (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_value       (m_axis_tdata)
    );

endmodule
